// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/mcrf_pkg.sv -----
// Types, codes and the CRC-16 step shared by the coil request framer.
`default_nettype none

package mcrf_pkg;

    localparam logic [1:0] CMD_READ_COILS    = 2'd0;
    localparam logic [1:0] CMD_WRITE_SINGLE  = 2'd1;
    localparam logic [1:0] CMD_WRITE_MULTI   = 2'd2;
    localparam logic [1:0] CMD_DATA_BYTE     = 2'd3;

    localparam logic [7:0] FC_READ_COILS     = 8'h01;
    localparam logic [7:0] FC_WRITE_SINGLE   = 8'h05;
    localparam logic [7:0] FC_WRITE_MULTI    = 8'h0F;

    localparam logic [15:0] COIL_ON          = 16'hFF00;
    localparam logic [15:0] COIL_OFF         = 16'h0000;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;

    localparam int unsigned HDR_BYTES        = 7;

    // Emitter job: literals, then optionally the two CRC bytes, or an error byte.
    typedef struct packed {
        logic [HDR_BYTES-1:0][7:0] data;
        logic [2:0]                nlit;
        logic                      tail;
        logic                      init;
        logic                      err;
    } job_t;

    function automatic logic [15:0] crc_add(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mcrf_decoder.sv -----
// Command decoder: turns an input transaction into an emitter job and tracks data bytes due.
`default_nettype none

module mcrf_decoder
    import mcrf_pkg::*;
#(
    parameter int unsigned MAX_COILS = 256,
    parameter int unsigned LEFT_W    = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [7:0]  s_slave_address,
    input  wire logic [15:0] s_first_coil,
    input  wire logic [15:0] s_count_or_value,
    input  wire logic [7:0]  s_data_byte,
    output logic             job_valid,
    input  wire logic        job_ready,
    output job_t             job
);

    logic              job_valid_reg;
    job_t              job_reg;
    job_t              job_next;
    logic [LEFT_W-1:0] left_reg;
    logic [LEFT_W-1:0] left_next;
    logic [15:0]       value;
    logic [16:0]       nbytes_sum;
    logic [13:0]       nbytes;
    logic [7:0]        func_code;
    logic              bad_count;
    logic              accept;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !job_valid_reg || job_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    assign nbytes_sum = {1'b0, s_count_or_value} + 17'd7;
    assign nbytes     = nbytes_sum[16:3];
    assign bad_count  = (s_count_or_value == 16'd0) ||
                        (s_count_or_value > 16'(MAX_COILS));

    always_comb begin
        value     = s_count_or_value;
        func_code = FC_READ_COILS;
        left_next = '0;
        job_next  = '0;
        case (s_command)
            CMD_DATA_BYTE: begin
                left_next = left_reg;
                if (left_reg == '0) begin
                    job_next.err = 1'b1;
                end else begin
                    left_next        = left_reg - LEFT_W'(1);
                    job_next.data[0] = s_data_byte;
                    job_next.nlit    = 3'd1;
                    job_next.tail    = (left_reg == LEFT_W'(1));
                end
            end
            default: begin
                case (s_command)
                    CMD_WRITE_SINGLE: begin
                        func_code = FC_WRITE_SINGLE;
                        value     = (s_count_or_value != 16'd0) ? COIL_ON : COIL_OFF;
                    end
                    CMD_WRITE_MULTI: func_code = FC_WRITE_MULTI;
                    default:         func_code = FC_READ_COILS;
                endcase
                job_next.data[0] = s_slave_address;
                job_next.data[1] = func_code;
                job_next.data[2] = s_first_coil[15:8];
                job_next.data[3] = s_first_coil[7:0];
                job_next.data[4] = value[15:8];
                job_next.data[5] = value[7:0];
                if (s_command == CMD_WRITE_MULTI) begin
                    if (bad_count) begin
                        job_next     = '0;
                        job_next.err = 1'b1;
                    end else begin
                        job_next.data[6] = nbytes[7:0];
                        job_next.nlit    = 3'd7;
                        job_next.init    = 1'b1;
                        left_next        = nbytes[LEFT_W-1:0];
                    end
                end else begin
                    job_next.nlit = 3'd6;
                    job_next.tail = 1'b1;
                    job_next.init = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            left_reg      <= '0;
        end else begin
            if (accept) begin
                job_valid_reg <= 1'b1;
                left_reg      <= left_next;
            end else if (job_ready) begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_reg <= job_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mcrf_emitter.sv -----
// Byte emitter: one byte per cycle unless stalled; folds bytes into the CRC and drives the output register.
`default_nettype none

module mcrf_emitter
    import mcrf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       job_valid,
    output logic            job_ready,
    input  wire job_t       job,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_frame_byte,
    output logic            m_frame_end,
    output logic            m_error
);

    job_t        cur_reg;
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic        active_reg;
    logic        active_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;
    logic        out_err_reg;

    logic        slot_free;
    logic        take;
    logic        emit_en;
    job_t        src;
    logic [3:0]  p;
    logic [3:0]  total;
    logic [3:0]  nlit_w;
    logic [15:0] base;
    logic [7:0]  byte_next;
    logic        end_next;
    logic        is_lit;

    assign slot_free = !out_valid_reg || m_ready;
    assign job_ready = slot_free && !active_reg;
    assign take      = job_ready && job_valid;
    assign emit_en   = slot_free && (active_reg || job_valid);

    always_comb begin
        src    = take ? job : cur_reg;
        p      = take ? 4'd0 : pos_reg;
        base   = (take && job.init) ? CRC_INIT : crc_reg;
        nlit_w = {1'b0, src.nlit};
        total  = src.err ? 4'd1 : (nlit_w + (src.tail ? 4'd2 : 4'd0));
        is_lit = !src.err && (p < nlit_w);
        end_next = 1'b0;
        if (src.err) begin
            byte_next = 8'h00;
            end_next  = 1'b1;
        end else if (is_lit) begin
            byte_next = src.data[p[2:0]];
        end else if (p == nlit_w) begin
            byte_next = base[7:0];
        end else begin
            byte_next = base[15:8];
            end_next  = 1'b1;
        end
        crc_next    = is_lit ? crc_add(base, byte_next) : crc_reg;
        pos_next    = p + 4'd1;
        active_next = (pos_next != total);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            if (emit_en) begin
                active_reg    <= active_next;
                pos_reg       <= pos_next;
                crc_reg       <= crc_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cur_reg <= job;
        end
        if (emit_en) begin
            out_byte_reg <= byte_next;
            out_end_reg  <= end_next;
            out_err_reg  <= src.err;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_byte = out_byte_reg;
    assign m_frame_end  = out_end_reg;
    assign m_error      = out_err_reg;

endmodule

`default_nettype wire

// ----- sv/modbus_coil_request_framer_core.sv -----
// Top level of the Modbus RTU coil request framer.
//
// Input channel (s_*): one command per transaction. Commands 0 and 1 give a
// complete eight-byte frame with CRC; command 2 gives the seven-byte header of
// a write multiple coils frame, and each following command 3 gives one data
// byte, the last of them followed by the CRC low and high bytes. A bad coil
// count or an unexpected data byte gives a single error byte instead.
// Output channel (m_*): one frame byte per transaction, in send order;
// m_frame_end marks the last byte of a frame or an error byte.
// The first byte of a command is registered in the decoder job register and
// then in the emitter output register before it is offered.
// Throughput: the emitter sends one byte per cycle while the output is not
// stalled. A command gives eight output bytes for a full frame, seven for a
// multiple-coil header, one per data byte and three for the last.
// The decoder register takes the next command while the emitter works.
// Reset clears all pending work, the byte count due and the CRC.
// When the receiver stalls, the output byte holds and the emitter and then
// the input channel stop in turn; nothing is lost.
`default_nettype none

module modbus_coil_request_framer_core
    import mcrf_pkg::*;
#(
    parameter int unsigned MAX_COILS = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [7:0]  s_slave_address,
    input  wire logic [15:0] s_first_coil,
    input  wire logic [15:0] s_count_or_value,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_frame_byte,
    output logic             m_frame_end,
    output logic             m_error
);

    localparam int unsigned LEFT_W = $clog2((MAX_COILS + 7) / 8 + 1);

    logic job_valid;
    logic job_ready;
    job_t job;

    mcrf_decoder #(
        .MAX_COILS (MAX_COILS),
        .LEFT_W    (LEFT_W)
    ) u_decoder (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_slave_address  (s_slave_address),
        .s_first_coil     (s_first_coil),
        .s_count_or_value (s_count_or_value),
        .s_data_byte      (s_data_byte),
        .job_valid        (job_valid),
        .job_ready        (job_ready),
        .job              (job)
    );

    mcrf_emitter u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_end  (m_frame_end),
        .m_error      (m_error)
    );

endmodule

`default_nettype wire

// ----- sv/mcrf_checker.sv -----
// Port-level checks for the coil request framer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module mcrf_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_frame_byte,
    input wire logic       m_frame_end,
    input wire logic       m_error
);

    // A stalled result transaction keeps its byte and flags.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_frame_byte) && $stable(m_frame_end) && $stable(m_error))

    // An error result is a single, zero-valued, frame-ending byte.
    `ASSERT_IMPLIES(a_err_ends, aclk, aresetn, m_valid && m_error, m_frame_end && (m_frame_byte == 8'h00))

    // Nothing is offered in the cycle after reset.
    `ASSERT_NEXT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_valid)

    // An idle output stays idle unless a transaction was accepted at the previous edge.
    `ASSERT_NEXT(a_min_latency, aclk, aresetn, !m_valid && !$past(s_valid && s_ready), !m_valid)

endmodule

bind modbus_coil_request_framer_core mcrf_checker u_mcrf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_byte (m_frame_byte),
    .m_frame_end  (m_frame_end),
    .m_error      (m_error)
);

`default_nettype wire

// ----- bench/modbus_coil_request_framer_core_tb.sv -----
// Self-checking bench for the coil request framer: queued commands in, predicted frame bytes out.
`timescale 1ns / 1ps

module modbus_coil_request_framer_core_tb
    import mcrf_pkg::*;
();

    localparam int unsigned MAX_COILS = 256;
    localparam int unsigned RANDOM_ITEMS = 100;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  addr;
        logic [15:0] first;
        logic [15:0] cv;
        logic [7:0]  db;
    } coil_cmd_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       error;
    } frame_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    coil_cmd_t drv_cmd = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_frame_byte;
    logic m_frame_end;
    logic m_error;

    coil_cmd_t command_queue[$];
    frame_out_t expected_bytes[$];

    // Shadow of the framer's multiple-coil state.
    logic [15:0] multi_crc = CRC_INIT;
    int unsigned data_due = 0;

    logic s_fired = 1'b0;
    logic m_fired = 1'b0;
    int unsigned s_gap = 0;
    int unsigned m_hold = 0;
    int unsigned ready_gap;
    bit steady_mode[2];
    int unsigned mismatches = 0;
    frame_out_t want;
    frame_out_t got;

    always #6 aclk = ~aclk;

    modbus_coil_request_framer_core #(
        .MAX_COILS(MAX_COILS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(drv_cmd.cmd),
        .s_slave_address(drv_cmd.addr),
        .s_first_coil(drv_cmd.first),
        .s_count_or_value(drv_cmd.cv),
        .s_data_byte(drv_cmd.db),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_frame_byte(m_frame_byte),
        .m_frame_end(m_frame_end),
        .m_error(m_error)
    );

    // Reflected CRC-16, fed one data bit at a time.
    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb = acc[0] ^ b[k];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void expect_byte(input logic [7:0] b, input logic e, input logic err);
        frame_out_t r;
        r.frame_byte = b;
        r.frame_end = e;
        r.error = err;
        expected_bytes.push_back(r);
    endfunction

    task automatic predict_frame(input coil_cmd_t c);
        logic [7:0] hdr[7];
        logic [15:0] word;
        logic [15:0] crc;
        logic [15:0] nbytes;
        int unsigned nhdr;
        if (c.cmd == CMD_DATA_BYTE) begin
            if (data_due == 0) begin
                expect_byte(8'h00, 1'b1, 1'b1);
            end else begin
                multi_crc = crc16_byte(multi_crc, c.db);
                data_due--;
                expect_byte(c.db, 1'b0, 1'b0);
                if (data_due == 0) begin
                    expect_byte(multi_crc[7:0], 1'b0, 1'b0);
                    expect_byte(multi_crc[15:8], 1'b1, 1'b0);
                    multi_crc = CRC_INIT;
                end
            end
            return;
        end
        // A header command drops whatever multiple-coil frame was pending.
        data_due = 0;
        multi_crc = CRC_INIT;
        word = c.cv;
        if (c.cmd == CMD_WRITE_SINGLE) begin
            word = (c.cv != 0) ? COIL_ON : COIL_OFF;
        end
        if (c.cmd == CMD_WRITE_MULTI && (c.cv == 0 || c.cv > MAX_COILS)) begin
            expect_byte(8'h00, 1'b1, 1'b1);
            return;
        end
        hdr[0] = c.addr;
        case (c.cmd)
            CMD_READ_COILS:   hdr[1] = FC_READ_COILS;
            CMD_WRITE_SINGLE: hdr[1] = FC_WRITE_SINGLE;
            default:          hdr[1] = FC_WRITE_MULTI;
        endcase
        hdr[2] = c.first[15:8];
        hdr[3] = c.first[7:0];
        hdr[4] = word[15:8];
        hdr[5] = word[7:0];
        nbytes = (c.cv + 16'd7) >> 3;
        hdr[6] = nbytes[7:0];
        nhdr = (c.cmd == CMD_WRITE_MULTI) ? 7 : 6;
        crc = CRC_INIT;
        for (int i = 0; i < nhdr; i++) begin
            crc = crc16_byte(crc, hdr[i]);
            expect_byte(hdr[i], 1'b0, 1'b0);
        end
        if (c.cmd == CMD_WRITE_MULTI) begin
            multi_crc = crc;
            data_due = 32'(nbytes);
        end else begin
            expect_byte(crc[7:0], 1'b0, 1'b0);
            expect_byte(crc[15:8], 1'b1, 1'b0);
        end
    endtask

    function automatic void queue_cmd(input logic [1:0] cmd, input logic [15:0] first,
                                      input logic [15:0] cv, input logic [7:0] db);
        coil_cmd_t c;
        c.cmd = cmd;
        c.addr = 8'($urandom_range(0, 255));
        c.first = first;
        c.cv = cv;
        c.db = db;
        command_queue.push_back(c);
    endfunction

    // Mostly short gaps, now and then a long one, with stretches of none at all.
    function automatic int unsigned next_gap(input int side);
        int unsigned r;
        if ($urandom_range(0, 39) == 0) begin
            steady_mode[side] = !steady_mode[side];
        end
        if (steady_mode[side]) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Command driver: a new transaction is presented only once the last one was taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap <= 0;
        end else if (s_valid && !s_fired) begin
            s_valid <= 1'b1;
        end else if (s_gap != 0) begin
            s_valid <= 1'b0;
            s_gap <= s_gap - 1;
        end else if (command_queue.size() != 0) begin
            drv_cmd <= command_queue.pop_front();
            s_valid <= 1'b1;
            s_gap <= next_gap(0);
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_hold <= 0;
        end else if (m_hold != 0) begin
            m_ready <= 1'b0;
            m_hold <= m_hold - 1;
        end else if (m_fired) begin
            ready_gap = next_gap(1);
            m_ready <= (ready_gap == 0);
            m_hold <= (ready_gap == 0) ? 0 : ready_gap - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Prediction is made before checking, so that an expectation is in place in good time.
    always @(posedge aclk) begin
        s_fired <= aresetn && s_valid && s_ready;
        m_fired <= aresetn && m_valid && m_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_frame(drv_cmd);
            end
            if (m_valid && m_ready) begin
                got.frame_byte = m_frame_byte;
                got.frame_end = m_frame_end;
                got.error = m_error;
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected byte: byte=%02h end=%b err=%b",
                                 got.frame_byte, got.frame_end, got.error);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.frame_byte !== want.frame_byte || got.frame_end !== want.frame_end
                            || got.error !== want.error) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("mismatch: expected byte=%02h end=%b err=%b, got byte=%02h end=%b err=%b",
                                     want.frame_byte, want.frame_end, want.error,
                                     got.frame_byte, got.frame_end, got.error);
                        end
                    end
                end
            end
        end
    end

    initial begin
        int unsigned random_items;
        int unsigned kind;
        int unsigned count;
        int unsigned nbytes;
        int unsigned cut;

        // Directed part: field extremes, every command and the special cases.
        queue_cmd(CMD_READ_COILS, 16'h0000, 16'h0000, 8'h00);
        queue_cmd(CMD_READ_COILS, 16'hFFFF, 16'hFFFF, 8'hFF);
        queue_cmd(CMD_WRITE_SINGLE, 16'h1234, 16'h0000, 8'h00);
        queue_cmd(CMD_WRITE_SINGLE, 16'hFFFF, 16'h0001, 8'hFF);
        queue_cmd(CMD_WRITE_SINGLE, 16'h0000, 16'h8000, 8'h5A);
        queue_cmd(CMD_DATA_BYTE, 16'h0000, 16'h0000, 8'hA5);
        queue_cmd(CMD_WRITE_MULTI, 16'h0010, 16'h0000, 8'h00);
        queue_cmd(CMD_WRITE_MULTI, 16'h0010, 16'(MAX_COILS + 1), 8'h00);
        queue_cmd(CMD_WRITE_MULTI, 16'h0010, 16'hFFFF, 8'h00);
        queue_cmd(CMD_WRITE_MULTI, 16'hFFFF, 16'h0001, 8'h00);
        queue_cmd(CMD_DATA_BYTE, 16'h0000, 16'h0000, 8'hFF);
        queue_cmd(CMD_WRITE_MULTI, 16'h0000, 16'h0009, 8'h00);
        queue_cmd(CMD_DATA_BYTE, 16'h0000, 16'h0000, 8'h00);
        queue_cmd(CMD_DATA_BYTE, 16'h0000, 16'h0000, 8'hAA);
        // A read command arriving mid-frame abandons it, and the data byte after it is stray.
        queue_cmd(CMD_WRITE_MULTI, 16'h0100, 16'h0010, 8'h00);
        queue_cmd(CMD_DATA_BYTE, 16'h0000, 16'h0000, 8'h55);
        queue_cmd(CMD_READ_COILS, 16'h0002, 16'h0008, 8'h00);
        queue_cmd(CMD_DATA_BYTE, 16'h0000, 16'h0000, 8'h0F);
        // A fresh header in the middle of a frame restarts it.
        queue_cmd(CMD_WRITE_MULTI, 16'h0200, 16'h0018, 8'h00);
        queue_cmd(CMD_DATA_BYTE, 16'h0000, 16'h0000, 8'hF0);
        queue_cmd(CMD_WRITE_MULTI, 16'h0300, 16'(MAX_COILS), 8'h00);
        queue_cmd(CMD_WRITE_SINGLE, 16'h0004, 16'hFFFF, 8'h00);

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                queue_cmd(CMD_READ_COILS, 16'($urandom), 16'($urandom), 8'($urandom));
                random_items++;
            end else if (kind < 35) begin
                queue_cmd(CMD_WRITE_SINGLE, 16'($urandom),
                          ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom),
                          8'($urandom));
                random_items++;
            end else if (kind < 85) begin
                case ($urandom_range(0, 9))
                    0:       count = MAX_COILS;
                    1:       count = $urandom_range(MAX_COILS - 7, MAX_COILS);
                    default: count = $urandom_range(1, 24);
                endcase
                nbytes = (count + 7) / 8;
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nbytes - 1) : nbytes;
                queue_cmd(CMD_WRITE_MULTI, 16'($urandom), 16'(count), 8'($urandom));
                for (int i = 0; i < cut; i++) begin
                    queue_cmd(CMD_DATA_BYTE, 16'($urandom), 16'($urandom), 8'($urandom));
                end
                random_items += cut + 1;
            end else if (kind < 95) begin
                queue_cmd(CMD_WRITE_MULTI, 16'($urandom),
                          $urandom_range(0, 1) ? 16'h0000
                                               : 16'($urandom_range(MAX_COILS + 1, 65535)),
                          8'($urandom));
                random_items++;
            end else begin
                queue_cmd(CMD_DATA_BYTE, 16'($urandom), 16'($urandom), 8'($urandom));
                random_items++;
            end
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (command_queue.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (expected_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("modbus_coil_request_framer_core_tb: done, clean");
        end else begin
            $display("modbus_coil_request_framer_core_tb: done, errors");
        end
        $finish;
    end

    // Far beyond the slowest correct run with every stall at its longest.
    initial begin
        #10_000_000;
        $display("modbus_coil_request_framer_core_tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/mcrf_pkg.sv
sv/mcrf_decoder.sv
sv/mcrf_emitter.sv
sv/modbus_coil_request_framer_core.sv
sv/mcrf_checker.sv
bench/modbus_coil_request_framer_core_tb.sv
